FILE: hdl/block_free_list_allocator_assert.svh
// Assertion macros for the block free list allocator.
`ifndef BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define BFLA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bfla assertion failed");
`define BFLA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bfla assertion failed");
`else
`define BFLA_ASSERT(lbl, clk, rstn, prop)
`define BFLA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: hdl/bfla_pkg.sv
// Shared types and constants for the block free list allocator.
package bfla_pkg;

    localparam int NUM_BLOCKS = 1024;
    localparam int ID_W       = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = ID_W + 1;

    localparam logic [ID_W-1:0]  TOP_ID    = ID_W'(NUM_BLOCKS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    localparam logic CMD_ALLOC  = 1'b0;
    localparam logic CMD_FREE   = 1'b1;
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_INDEX = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_BAD_FREE  = 2'd2
    } t_status;

    typedef enum logic {
        FS_READY,
        FS_FETCH
    } t_fetch_state;

    typedef struct packed {
        logic            pop;
        logic            push;
        logic [ID_W-1:0] push_id;
    } t_list_ctl;

    typedef struct packed {
        logic            busy;
        logic [ID_W-1:0] head;
    } t_list_stat;

endpackage

FILE: hdl/bfla_list.sv
// Linked free list: head, prefetched next link and the link memory.
module bfla_list
    import bfla_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_list_ctl  i_ctl,
    output t_list_stat o_stat
);

`include "block_free_list_allocator_assert.svh"

    t_fetch_state    r_state;
    t_fetch_state    n_state;
    logic [ID_W-1:0] r_head;
    logic [ID_W-1:0] r_head_next;
    logic [ID_W-1:0] r_rd_data;
    logic [ID_W-1:0] r_links [NUM_BLOCKS];

    always_comb begin
        unique case (r_state)
            FS_READY: n_state = i_ctl.pop ? FS_FETCH : FS_READY;
            FS_FETCH: n_state = FS_READY;
            default:  n_state = FS_READY;
        endcase
    end

    always_comb begin
        o_stat.busy = (r_state == FS_FETCH);
        o_stat.head = r_head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_READY;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            if (i_ctl.pop) begin
                r_head <= r_head_next;
            end else if (i_ctl.push) begin
                r_head <= i_ctl.push_id;
            end
        end
    end

    // next link of the head: refilled from memory after a pop, set to the old head on a push
    always_ff @(posedge i_clk) begin
        if (r_state == FS_FETCH) begin
            r_head_next <= r_rd_data;
        end else if (i_ctl.push) begin
            r_head_next <= r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_links[i_ctl.push_id] <= r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_rd_data <= r_links[r_head_next];
        end
    end

    `BFLA_ASSERT(a_pop_fetches, i_clk, i_rst_n, i_ctl.pop |=> o_stat.busy)
    `BFLA_ASSERT(a_fetch_one_cycle, i_clk, i_rst_n, o_stat.busy |=> !o_stat.busy)
    `BFLA_ASSERT(a_no_pop_when_busy, i_clk, i_rst_n,
        o_stat.busy |-> !(i_ctl.pop || i_ctl.push))

endmodule

FILE: hdl/block_free_list_allocator.sv
// Top level of the block free list allocator.
// Usage:
//   Drive i_cmd, i_block_kind and i_free_id with i_start high; the item is
//   taken at a rising edge where o_busy is low. i_cmd selects allocate or
//   free, i_block_kind data or index block, i_free_id the block to free.
//   In the next cycle o_done pulses for exactly one cycle with o_granted_id,
//   o_status and the counts after the item. The receiver cannot stall;
//   results must be captured on the o_done cycle.
//   A free, an allocate served from the high-water mark, or a rejected
//   item allows a new item in the next cycle. An allocate that pops the
//   free list raises o_busy while the link of the new list head is read
//   from the link memory, so no new item is taken in the next cycle.
//   Block 0 is reserved. Freeing block 0 or a block above the high-water
//   mark is ignored with a bad-free status; an allocate with an empty list
//   and a full store reports exhaustion. Counts saturate at both ends.
//   Synchronous reset empties the list, clears the high-water mark and the
//   counts; the link memory is not cleared, as a link is read only after
//   a free has written it.
module block_free_list_allocator
    import bfla_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic             i_cmd,
    input  logic             i_block_kind,
    input  logic [ID_W-1:0]  i_free_id,
    output logic             o_done,
    output logic [ID_W-1:0]  o_granted_id,
    output logic [1:0]       o_status,
    output logic [CNT_W-1:0] o_data_blocks,
    output logic [CNT_W-1:0] o_index_blocks,
    output logic [CNT_W-1:0] o_idle_blocks
);

`include "block_free_list_allocator_assert.svh"

    t_list_ctl        list_ctl;
    t_list_stat       list_stat;

    logic             accept;
    logic             list_empty;
    logic             do_alloc;
    logic             do_free;
    logic             bad_free;
    logic [ID_W-1:0]  n_granted;
    t_status          n_status;

    logic             r_done;
    logic [ID_W-1:0]  r_granted;
    t_status          r_status;
    logic [ID_W-1:0]  r_high_water;
    logic [ID_W-1:0]  n_high_water;
    logic [CNT_W-1:0] r_data_total;
    logic [CNT_W-1:0] r_index_total;
    logic [CNT_W-1:0] r_idle_total;
    logic [CNT_W-1:0] n_data_total;
    logic [CNT_W-1:0] n_index_total;
    logic [CNT_W-1:0] n_idle_total;

    bfla_list u_list (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (list_ctl),
        .o_stat (list_stat)
    );

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] count_down(input logic [CNT_W-1:0] v);
        return (v == '0) ? v : v - CNT_W'(1);
    endfunction

    assign o_busy     = list_stat.busy;
    assign accept     = i_start && !list_stat.busy;
    assign list_empty = (list_stat.head == '0);
    assign bad_free   = (i_free_id == '0) || (i_free_id > r_high_water);
    assign do_alloc   = accept && (i_cmd == CMD_ALLOC);
    assign do_free    = accept && (i_cmd == CMD_FREE) && !bad_free;

    always_comb begin
        list_ctl.pop     = do_alloc && !list_empty;
        list_ctl.push    = do_free;
        list_ctl.push_id = i_free_id;
    end

    always_comb begin
        n_granted     = '0;
        n_status      = STAT_OK;
        n_high_water  = r_high_water;
        n_data_total  = r_data_total;
        n_index_total = r_index_total;
        n_idle_total  = r_idle_total;
        if (i_cmd == CMD_ALLOC) begin
            priority if (!list_empty) begin
                n_granted    = list_stat.head;
                n_idle_total = count_down(r_idle_total);
            end else if (r_high_water < TOP_ID) begin
                n_high_water = r_high_water + ID_W'(1);
                n_granted    = n_high_water;
            end else begin
                n_status = STAT_EXHAUSTED;
            end
            if (n_status == STAT_OK) begin
                if (i_block_kind == KIND_DATA) begin
                    n_data_total = count_up(r_data_total);
                end else begin
                    n_index_total = count_up(r_index_total);
                end
            end
        end else begin
            if (bad_free) begin
                n_status = STAT_BAD_FREE;
            end else begin
                n_idle_total = count_up(r_idle_total);
                if (i_block_kind == KIND_DATA) begin
                    n_data_total = count_down(r_data_total);
                end else begin
                    n_index_total = count_down(r_index_total);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done        <= 1'b0;
            r_high_water  <= '0;
            r_data_total  <= '0;
            r_index_total <= '0;
            r_idle_total  <= '0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_high_water  <= n_high_water;
                r_data_total  <= n_data_total;
                r_index_total <= n_index_total;
                r_idle_total  <= n_idle_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_granted <= n_granted;
            r_status  <= n_status;
        end
    end

    assign o_done         = r_done;
    assign o_granted_id   = r_granted;
    assign o_status       = r_status;
    assign o_data_blocks  = r_data_total;
    assign o_index_blocks = r_index_total;
    assign o_idle_blocks  = r_idle_total;

    `BFLA_ASSERT(a_accept_done, i_clk, i_rst_n, accept |=> o_done)
    `BFLA_ASSERT(a_idle_no_done, i_clk, i_rst_n, !accept |=> !o_done)
    `BFLA_ASSERT(a_grant_ok, i_clk, i_rst_n,
        (o_done && o_granted_id != '0) |-> (o_status == STAT_OK))
    `BFLA_ASSERT(a_list_empty_stable, i_clk, i_rst_n,
        (!accept && !list_stat.busy) |=> $stable(list_stat.head))

endmodule

FILE: tb/sv/bfla_checker.sv
// Checker for the block free list allocator: predicts every result and compares it.
module bfla_checker
    import bfla_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  logic             i_cmd,
    input  logic             i_block_kind,
    input  logic [ID_W-1:0]  i_free_id,
    input  logic             i_done,
    input  logic [ID_W-1:0]  i_granted_id,
    input  logic [1:0]       i_status,
    input  logic [CNT_W-1:0] i_data_blocks,
    input  logic [CNT_W-1:0] i_index_blocks,
    input  logic [CNT_W-1:0] i_idle_blocks,
    output int               o_errors,
    output int               o_pending,
    output int               o_grants,
    output int               o_exhausts,
    output int               o_frees,
    output int               o_rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ID_W-1:0]  granted;
        t_status          status;
        logic [CNT_W-1:0] data_cnt;
        logic [CNT_W-1:0] index_cnt;
        logic [CNT_W-1:0] idle_cnt;
    } t_answer;

    logic [ID_W-1:0]  head;
    logic [ID_W-1:0]  high_water;
    logic [ID_W-1:0]  link [NUM_BLOCKS];
    logic [CNT_W-1:0] data_cnt;
    logic [CNT_W-1:0] index_cnt;
    logic [CNT_W-1:0] idle_cnt;
    t_answer          answers[$];
    int               err_total;
    int               grants, exhausts, frees, rejects;

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] sat_dec(logic [CNT_W-1:0] v);
        return (v == '0) ? v : v - CNT_W'(1);
    endfunction

    // Applies one item to the shadow free list and returns the answer it must produce.
    function automatic t_answer apply_item(logic cmd, logic kind, logic [ID_W-1:0] id);
        t_answer a;
        a = '0;
        a.status = STAT_OK;
        if (cmd == CMD_ALLOC) begin
            if (head != '0) begin
                a.granted = head;
                head = link[head];
                idle_cnt = sat_dec(idle_cnt);
            end else if (high_water != TOP_ID) begin
                high_water = high_water + ID_W'(1);
                a.granted = high_water;
            end else begin
                a.status = STAT_EXHAUSTED;
            end
            if (a.status == STAT_OK) begin
                if (kind == KIND_DATA) begin
                    data_cnt = sat_inc(data_cnt);
                end else begin
                    index_cnt = sat_inc(index_cnt);
                end
            end
        end else if (id == '0 || id > high_water) begin
            a.status = STAT_BAD_FREE;
        end else begin
            link[id] = head;
            head = id;
            idle_cnt = sat_inc(idle_cnt);
            if (kind == KIND_DATA) begin
                data_cnt = sat_dec(data_cnt);
            end else begin
                index_cnt = sat_dec(index_cnt);
            end
        end
        a.data_cnt  = data_cnt;
        a.index_cnt = index_cnt;
        a.idle_cnt  = idle_cnt;
        return a;
    endfunction

    function automatic void check_field(string what, int expv, int actv);
        if (expv != actv) begin
            if (err_total < 10) begin
                $display("mismatch %s: expected %0d, got %0d", what, expv, actv);
            end
            err_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            head       = '0;
            high_water = '0;
            data_cnt   = '0;
            index_cnt  = '0;
            idle_cnt   = '0;
            answers.delete();
        end else begin
            if (i_done) begin
                if (answers.size() == 0) begin
                    if (err_total < 10) begin
                        $display("mismatch: result with no item outstanding");
                    end
                    err_total++;
                end else begin
                    want = answers.pop_front();
                    check_field("granted_id", int'(want.granted), int'(i_granted_id));
                    check_field("status", int'(want.status), int'(i_status));
                    check_field("data_blocks", int'(want.data_cnt), int'(i_data_blocks));
                    check_field("index_blocks", int'(want.index_cnt), int'(i_index_blocks));
                    check_field("idle_blocks", int'(want.idle_cnt), int'(i_idle_blocks));
                end
            end
            if (i_start && !i_busy) begin
                want = apply_item(i_cmd, i_block_kind, i_free_id);
                answers.push_back(want);
                if (i_cmd == CMD_ALLOC) begin
                    if (want.status == STAT_OK) grants++;
                    else exhausts++;
                end else begin
                    if (want.status == STAT_OK) frees++;
                    else rejects++;
                end
            end
        end
        o_errors   <= err_total;
        o_pending  <= answers.size();
        o_grants   <= grants;
        o_exhausts <= exhausts;
        o_frees    <= frees;
        o_rejects  <= rejects;
    end

endmodule

FILE: tb/sv/tb_block_free_list_allocator.sv
// Top of the block free list allocator testbench: clock, reset, stimulus and verdict.
module tb_block_free_list_allocator
    import bfla_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            kind;
    } t_owned;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    logic             i_cmd;
    logic             i_block_kind;
    logic [ID_W-1:0]  i_free_id;
    logic             o_done;
    logic [ID_W-1:0]  o_granted_id;
    logic [1:0]       o_status;
    logic [CNT_W-1:0] o_data_blocks;
    logic [CNT_W-1:0] o_index_blocks;
    logic [CNT_W-1:0] o_idle_blocks;

    int errors, pending, grants, exhausts, frees, rejects;

    t_owned          owned[$];
    logic            kinds_in_flight[$];
    int              exhaust_seen;
    int              hw_seen;
    int              stall_cycles;
    bit              idling;

    block_free_list_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_cmd          (i_cmd),
        .i_block_kind   (i_block_kind),
        .i_free_id      (i_free_id),
        .o_done         (o_done),
        .o_granted_id   (o_granted_id),
        .o_status       (o_status),
        .o_data_blocks  (o_data_blocks),
        .o_index_blocks (o_index_blocks),
        .o_idle_blocks  (o_idle_blocks)
    );

    bfla_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_cmd          (i_cmd),
        .i_block_kind   (i_block_kind),
        .i_free_id      (i_free_id),
        .i_done         (o_done),
        .i_granted_id   (o_granted_id),
        .i_status       (o_status),
        .i_data_blocks  (o_data_blocks),
        .i_index_blocks (o_index_blocks),
        .i_idle_blocks  (o_idle_blocks),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_grants       (grants),
        .o_exhausts     (exhausts),
        .o_frees        (frees),
        .o_rejects      (rejects)
    );

    always #5 i_clk = ~i_clk;

    // Tracks blocks currently held so that frees can target them without double freeing.
    always @(posedge i_clk) begin
        logic kind;
        int   idx;
        if (i_rst_n) begin
            if (o_done) begin
                kind = (kinds_in_flight.size() != 0) ? kinds_in_flight.pop_front() : KIND_DATA;
                if (o_status == STAT_OK && o_granted_id != '0) begin
                    owned.push_back({o_granted_id, kind});
                    if (int'(o_granted_id) > hw_seen) hw_seen = int'(o_granted_id);
                end
                if (o_status == STAT_EXHAUSTED) exhaust_seen++;
            end
            if (i_start && !o_busy) begin
                kinds_in_flight.push_back(i_block_kind);
                if (i_cmd == CMD_FREE) begin
                    idx = 0;
                    while (idx < owned.size()) begin
                        if (owned[idx].id == i_free_id) owned.delete(idx);
                        else idx++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic rand_kind();
        return 1'($urandom_range(0, 1));
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic cmd, input logic kind, input logic [ID_W-1:0] id);
        if (idling && $urandom_range(99) < 15) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge i_clk);
        end
        i_start      <= 1'b1;
        i_cmd        <= cmd;
        i_block_kind <= kind;
        i_free_id    <= id;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    task automatic send_alloc(input logic kind);
        send_item(CMD_ALLOC, kind, ID_W'($urandom_range(0, NUM_BLOCKS - 1)));
    endtask

    task automatic send_owned_free();
        int     pick;
        t_owned blk;
        if (owned.size() == 0) begin
            send_alloc(rand_kind());
        end else begin
            pick = int'($urandom_range(0, owned.size() - 1));
            blk = owned[pick];
            send_item(CMD_FREE, ($urandom_range(99) < 90) ? blk.kind : ~blk.kind, blk.id);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int r;
        int n;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_cmd        = CMD_ALLOC;
        i_block_kind = KIND_DATA;
        i_free_id    = '0;
        idling       = 1'b1;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: high-water grants, rejected frees, wrong kind, pops from the list
        send_item(CMD_ALLOC, KIND_DATA, '0);
        send_item(CMD_ALLOC, KIND_INDEX, '1);
        send_item(CMD_ALLOC, KIND_DATA, '0);
        send_item(CMD_FREE, KIND_DATA, '0);
        send_item(CMD_FREE, KIND_INDEX, '1);
        send_item(CMD_FREE, KIND_DATA, ID_W'(4));
        send_item(CMD_FREE, KIND_INDEX, ID_W'(2));
        send_item(CMD_FREE, KIND_INDEX, ID_W'(1));
        send_item(CMD_ALLOC, KIND_INDEX, '0);
        send_item(CMD_ALLOC, KIND_DATA, '0);
        send_item(CMD_ALLOC, KIND_DATA, '1);
        send_item(CMD_FREE, KIND_DATA, ID_W'(4));
        send_item(CMD_FREE, KIND_DATA, ID_W'(3));
        send_item(CMD_ALLOC, KIND_INDEX, '0);
        send_item(CMD_ALLOC, KIND_INDEX, '0);
        send_item(CMD_ALLOC, KIND_DATA, '0);
        send_item(CMD_FREE, KIND_INDEX, ID_W'(5));
        drain();

        // mixed traffic on a growing store
        repeat (100) begin
            r = $urandom_range(99);
            if (r < 55) begin
                send_alloc(rand_kind());
            end else if (r < 85) begin
                send_owned_free();
            end else if (hw_seen < NUM_BLOCKS - 2 && r < 95) begin
                send_item(CMD_FREE, rand_kind(),
                          ID_W'($urandom_range(hw_seen + 2, NUM_BLOCKS - 1)));
            end else begin
                send_item(CMD_FREE, rand_kind(), '0);
            end
        end
        drain();

        // fill the store until it reports exhaustion repeatedly, back to back
        idling = 1'b0;
        n = 0;
        while (exhaust_seen < 12 && n < 3000) begin
            if ($urandom_range(99) < 98) send_alloc(rand_kind());
            else send_owned_free();
            n++;
        end
        idling = 1'b1;
        drain();

        // churn at a full store
        repeat (60) begin
            r = $urandom_range(99);
            if (r < 50) send_owned_free();
            else if (r < 90) send_alloc(rand_kind());
            else send_item(CMD_FREE, rand_kind(), '0);
        end
        drain();

        // double frees and random frees corrupt the list into loops
        send_item(CMD_FREE, KIND_DATA, ID_W'(7));
        send_item(CMD_FREE, KIND_DATA, ID_W'(7));
        repeat (40) begin
            if ($urandom_range(99) < 40) begin
                send_alloc(rand_kind());
            end else begin
                send_item(CMD_FREE, rand_kind(),
                          ID_W'($urandom_range(0, NUM_BLOCKS - 1)));
            end
        end
        drain();
        repeat (4) @(negedge i_clk);

        $display("run covered %0d grants, %0d exhausted allocates, %0d frees, %0d bad frees",
                 grants, exhausts, frees, rejects);
        $display("store filled to exhaustion, counts held at zero, list looped by double frees");
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, pending);
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/bfla_pkg.sv
hdl/bfla_list.sv
hdl/block_free_list_allocator.sv
tb/sv/bfla_checker.sv
tb/sv/tb_block_free_list_allocator.sv
